// ===== rtl/core/psaw_pkg.sv =====
// Shared types, constants and constant tables of the detuned saw bank.
package psaw_pkg;

   localparam int MAX_VOICES_DEF    = 8;
   localparam int DETUNE_VOICES_DEF = 7;
   localparam int PHASE_BITS_DEF    = 24;

   localparam int NOTE_W     = 7;
   localparam int CMD_W      = 2;
   localparam int OUT_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int OCT_W      = 3;
   localparam int DET_W      = 7;
   localparam int GAIN_W     = 16;
   localparam int MULT_W     = 32;
   localparam int BASE_W     = 32;
   localparam int DIVD_W     = 64;
   localparam int DIVS_W     = 32;
   localparam int EXPF_W     = 16;
   localparam int BASE_X_W   = 48;
   localparam int SHIFT_W    = 5;
   localparam int REM_W      = 4;

   localparam int SAMPLE_RATE = 44100;
   localparam int MIX_COEF    = 335544;
   localparam int OUT_MAX     = 8388607;
   localparam int OUT_MIN     = -8388608;

   localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DETUNE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SHIFT,
      CELL_PROC
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [NOTE_W-1:0]   note;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FSTART,
      ST_FDIV,
      ST_FEXP,
      ST_VOICE,
      ST_MUL,
      ST_ISTART,
      ST_IDIV,
      ST_ROT,
      ST_MIX1,
      ST_MIX2,
      ST_MIX3
   } seq_state_type;

   typedef logic [16:0][MULT_W-1:0]    root_tab_type;
   typedef logic [11:0][BASE_X_W-1:0]  base_tab_type;
   typedef logic [127:0][SHIFT_W-1:0]  shift_tab_type;
   typedef logic [127:0][REM_W-1:0]    rem_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (b > x) b = b >> 2;
      end
      for (int n = 0; n < 32; n++) begin
         if (b != 64'd0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // r[i] = 2^(2^-i) in Q30
   function automatic root_tab_type build_roots();
      root_tab_type t;
      logic [63:0]  v;
      v = 64'd1 << 31;
      t[0] = v[MULT_W-1:0];
      for (int i = 1; i <= 16; i++) begin
         v = isqrt64(v << 30);
         t[i] = v[MULT_W-1:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOT_TAB = build_roots();

   function automatic logic [63:0] exp2_const(input int f);
      logic [63:0] m;
      m = 64'd1 << 30;
      for (int i = 1; i <= 16; i++) begin
         if (((f >> (16 - i)) & 1) != 0) m = (m * 64'(ROOT_TAB[i])) >> 30;
      end
      return m;
   endfunction

   // 440 * 2^(r/12) in Q30, one entry per semitone
   function automatic base_tab_type build_base_tab();
      base_tab_type t;
      int           fr;
      for (int r = 0; r < 12; r++) begin
         fr = (r * 65536 + 6) / 12;
         t[r] = BASE_X_W'(64'd440 * exp2_const(fr));
      end
      return t;
   endfunction

   function automatic shift_tab_type build_shift_tab();
      shift_tab_type t;
      for (int n = 0; n < 128; n++) t[n] = SHIFT_W'(20 - (n + 3) / 12);
      return t;
   endfunction

   function automatic rem_tab_type build_rem_tab();
      rem_tab_type t;
      for (int n = 0; n < 128; n++) t[n] = REM_W'((n + 3) % 12);
      return t;
   endfunction

   localparam base_tab_type  BASE_TAB  = build_base_tab();
   localparam shift_tab_type SHIFT_TAB = build_shift_tab();
   localparam rem_tab_type   REM_TAB   = build_rem_tab();

endpackage

// ===== rtl/core/psaw_cell.sv =====
// Voice cell: one note and its row of oscillator phases.
module psaw_cell import psaw_pkg::*; #(
   parameter int DETUNE_VOICES = DETUNE_VOICES_DEF,
   parameter int PHASE_BITS    = PHASE_BITS_DEF
) (
   input  logic                                      clock,
   input  cell_ctrl_type                             ctrl,
   input  logic [NOTE_W-1:0]                         nb_note,
   input  logic [DETUNE_VOICES-1:0][PHASE_BITS-1:0]  nb_phases,
   input  logic [PHASE_BITS-1:0]                     upd_phase,
   output logic [NOTE_W-1:0]                         note,
   output logic [DETUNE_VOICES-1:0][PHASE_BITS-1:0]  phases
);

   localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

   logic [NOTE_W-1:0]                         note_ff, note_in;
   logic [DETUNE_VOICES-1:0][PHASE_BITS-1:0]  ph_ff, ph_in;

   always_comb begin
      note_in = note_ff;
      ph_in   = ph_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_LOAD: begin
            note_in = ctrl.note;
            for (int k = 0; k < DETUNE_VOICES; k++) ph_in[k] = HALF;
         end
         CELL_SHIFT: begin
            note_in = nb_note;
            ph_in   = nb_phases;
         end
         CELL_PROC: begin
            // rotate the row, the updated head goes to the tail
            for (int k = 0; k < DETUNE_VOICES - 1; k++) ph_in[k] = ph_ff[k+1];
            ph_in[DETUNE_VOICES-1] = upd_phase;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
      ph_ff   <= ph_in;
   end

   assign note   = note_ff;
   assign phases = ph_ff;

endmodule

// ===== rtl/core/psaw_div.sv =====
// Constant divider: each 16-bit quotient digit is estimated, then subtracted.
module psaw_div import psaw_pkg::*; #(
   parameter int DIVISOR = SAMPLE_RATE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   localparam int DIG_W  = 16;
   localparam int NDIG   = DIVD_W / DIG_W;
   localparam int CNT_W  = 2;
   localparam int CUR_W  = 2 * DIG_W;
   localparam int RC_S   = CUR_W + $clog2(DIVISOR);
   localparam int PROD_W = 2 * CUR_W + 1;
   // ceil(2^RC_S / DIVISOR) gives the exact digit for any 32-bit partial dividend
   localparam logic [CUR_W:0] RECIP =
      (CUR_W + 1)'(((64'd1 << RC_S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
   localparam logic [CUR_W-1:0] DVS = CUR_W'(DIVISOR);

   logic [DIG_W-1:0]  rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIG_W-1:0]  dig_ff, dig_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              phase_ff, phase_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CUR_W-1:0]  cur;
   logic [PROD_W-1:0] prod;
   logic [CUR_W-1:0]  rem_new;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dig_in   = dig_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cur      = {rem_ff, quo_ff[DIVD_W-1 -: DIG_W]};
      prod     = PROD_W'(cur) * PROD_W'(RECIP);
      rem_new  = cur - CUR_W'(dig_ff) * DVS;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         cnt_in   = '0;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            // estimate the digit from the reciprocal
            dig_in   = prod[RC_S +: DIG_W];
            phase_in = 1'b1;
         end else begin
            rem_in   = rem_new[DIG_W-1:0];
            quo_in   = {quo_ff[DIVD_W-DIG_W-1:0], dig_ff};
            phase_in = 1'b0;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NDIG - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dig_ff <= dig_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/psaw_exp2.sv =====
// Fractional power of two, one root factor per cycle.
module psaw_exp2 import psaw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [EXPF_W-1:0] frac,
   output logic              done,
   output logic [MULT_W-1:0] mant
);

   localparam int CNT_W = 5;

   logic [MULT_W-1:0] m_ff, m_in;
   logic [EXPF_W-1:0] f_ff, f_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [63:0]       prod;

   always_comb begin
      m_in    = m_ff;
      f_in    = f_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      prod    = {32'b0, m_ff} * {32'b0, ROOT_TAB[cnt_ff]};
      if (start) begin
         m_in    = MULT_W'(64'd1 << 30);
         f_in    = frac;
         cnt_in  = CNT_W'(1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (f_ff[EXPF_W-1]) m_in = prod[61:30];
         f_in   = {f_ff[EXPF_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(EXPF_W)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(1);
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      m_ff <= m_in;
      f_ff <= f_in;
   end

   assign done = done_ff;
   assign mant = m_ff;

endmodule

// ===== rtl/core/poly_detuned_saw_bank.sv =====
// Top level of the polyphonic detuned sawtooth bank.
// Channels: req_ (cmd, note_number), rsp_ (sample_value), csr_ (index, data) writes,
// all valid/ready; csr_ready is always high. Write registers only while idle.
// Note-on and note-off beats are taken without leaving idle and leave req_ready high:
// note-on appends a voice in the next free cell, note-off shifts the later cells
// down by one. A tick beat runs the sequencer and drops req_ready until done:
//   each of the D detune factors: start, divide by the cents span, then the
//   16-step exp unit; each active voice: per copy the multiplier, start, then
//   the divide by the sample rate, and a ring rotation after its last copy;
//   each empty cell slot: a ring shift; then the end of the voice walk and the
//   mix, which clamps the sample into the output register.
// req_ready rises again in the same cycle as rsp_valid, so the next beat can be taken then.
// Most of a tick is spent in the serial factor and divide units. A tick with no voice gives 0.
// A result waits in the output register; the block goes back to idle only once
// that register is free, so a stalled receiver holds the next tick in its mix.
// Reset empties the bank, zeroes the registers and clears the output beat.
module poly_detuned_saw_bank import psaw_pkg::*; #(
   parameter int MAX_VOICES    = MAX_VOICES_DEF,
   parameter int DETUNE_VOICES = DETUNE_VOICES_DEF,
   parameter int PHASE_BITS    = PHASE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [NOTE_W-1:0]     req_note_number,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [OUT_W-1:0] rsp_sample_value,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int MV       = MAX_VOICES;
   localparam int D        = DETUNE_VOICES;
   localparam int PB       = PHASE_BITS;
   localparam int DEN      = 1200 * (D - 1);
   localparam int DEN_HALF = DEN / 2;
   localparam int SH       = 46 - PB;
   localparam int CNT_W    = $clog2(MV + 1);
   localparam int JW       = $clog2(D);
   localparam int ACC_W    = PB + 1 + $clog2(MV * D);
   localparam int P1_W     = ACC_W + 20;
   localparam int Y_W      = ACC_W + 26 - PB;
   localparam int P2_W     = Y_W + 17;
   localparam int Z_W      = P2_W - 16;

   localparam logic [PB-1:0]           HALF   = {1'b1, {(PB-1){1'b0}}};
   localparam logic [DIVD_W-1:0]       RND_I  = DIVD_W'(1) << (SH - 1);
   localparam logic signed [P1_W-1:0]  COEF_P = P1_W'(MIX_COEF);
   localparam logic signed [P1_W-1:0]  RND1   = P1_W'(1) << (PB + 1);
   localparam logic signed [P2_W-1:0]  RND2   = P2_W'(1) << 15;
   localparam logic signed [Z_W-1:0]   Z_MAX  = Z_W'(OUT_MAX);
   localparam logic signed [Z_W-1:0]   Z_MIN  = Z_W'(OUT_MIN);

   seq_state_type state_ff, state_in;

   logic [OCT_W-1:0]  octave_ff;
   logic [DET_W-1:0]  detune_ff;
   logic [GAIN_W-1:0] volume_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  s_ff, s_in;
   logic [JW-1:0]     j_ff, j_in;
   logic [JW-1:0]     k_ff, k_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [DIVD_W-1:0] prod_ff, prod_in;
   logic              e16_ff, e16_in;
   logic signed [P1_W-1:0] p1_ff, p1_in;
   logic signed [P2_W-1:0] p2_ff, p2_in;
   logic signed [Y_W-1:0]  y_val;
   logic signed [Z_W-1:0]  z_val;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [MULT_W-1:0] mult_ff [D];
   logic              mult_shift;
   logic [MULT_W-1:0] mult_new;

   logic [NOTE_W-1:0]         cell_note [MV];
   logic [D-1:0][PB-1:0]      cell_ph   [MV];
   cell_ctrl_type             cell_ctrl [MV];
   logic [PB-1:0]             phase_new;
   logic [PB-1:0]             inc;
   logic signed [ACC_W-1:0]   term;

   logic              div_start, div_done;
   logic [DIVD_W-1:0] div_q;
   logic              fdiv_start, fdiv_done;
   logic [DIVD_W-1:0] fdiv_q;
   logic              exp_start, exp_done;
   logic [MULT_W-1:0] exp_m;

   logic [31:0]       e_lin;
   logic [DIVD_W-1:0] fact_num;
   logic [BASE_X_W-1:0] bx;
   logic [SHIFT_W-1:0]  bsh;
   logic [BASE_W-1:0]   base_calc;

   logic              off_found;
   logic [CNT_W-1:0]  off_hit;

   genvar g;
   generate
      for (g = 0; g < MV; g++) begin : g_cell
         psaw_cell #(
            .DETUNE_VOICES (D),
            .PHASE_BITS    (PB)
         ) u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[g]),
            .nb_note   (cell_note[(g + 1) % MV]),
            .nb_phases (cell_ph[(g + 1) % MV]),
            .upd_phase (phase_new),
            .note      (cell_note[g]),
            .phases    (cell_ph[g])
         );
      end
   endgenerate

   psaw_div #(
      .DIVISOR (DEN)
   ) u_fdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (fdiv_start),
      .dividend (fact_num),
      .done     (fdiv_done),
      .quotient (fdiv_q)
   );

   psaw_div #(
      .DIVISOR (SAMPLE_RATE)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   psaw_exp2 u_exp (
      .clock (clock),
      .reset (reset),
      .start (exp_start),
      .frac  (fdiv_q[EXPF_W-1:0]),
      .done  (exp_done),
      .mant  (exp_m)
   );

   // detune exponent numerator for copy j, Q16 octaves before the division
   assign e_lin = 32'(DEN) + 32'(detune_ff) * 32'({j_ff, 1'b0}) - 32'(detune_ff) * 32'(D - 1);
   assign fact_num = ({32'b0, e_lin} << 16) + DIVD_W'(DEN_HALF);

   assign bx  = BASE_TAB[REM_TAB[cell_note[0]]];
   assign bsh = SHIFT_TAB[cell_note[0]];
   assign base_calc = BASE_W'((bx + (BASE_X_W'(1) << (bsh - SHIFT_W'(1)))) >> bsh)
                    + (BASE_W'(octave_ff) << 16);

   assign inc       = PB'((div_q + RND_I) >> SH);
   assign phase_new = cell_ph[0][0] + inc;
   assign term      = ACC_W'($signed({1'b0, phase_new})) - ACC_W'($signed({1'b0, HALF}));

   assign y_val = Y_W'((p1_ff + RND1) >>> (PB + 2));
   assign z_val = Z_W'((p2_ff + RND2) >>> 16);

   // first active cell holding the released note
   always_comb begin
      off_found = 1'b0;
      off_hit   = '0;
      for (int i = MV - 1; i >= 0; i--) begin
         if (cell_note[i] == req_note_number && CNT_W'(i) < count_ff) begin
            off_found = 1'b1;
            off_hit   = CNT_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      s_in         = s_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      e16_in       = e16_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mult_shift   = 1'b0;
      mult_new     = mult_ff[0];
      div_start    = 1'b0;
      fdiv_start   = 1'b0;
      exp_start    = 1'b0;
      for (int i = 0; i < MV; i++) cell_ctrl[i] = '{op: CELL_HOLD, note: req_note_number};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_NOTE_ON: begin
                     if (count_ff < CNT_W'(MV)) begin
                        for (int i = 0; i < MV; i++) begin
                           if (CNT_W'(i) == count_ff) cell_ctrl[i].op = CELL_LOAD;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_NOTE_OFF: begin
                     if (off_found) begin
                        for (int i = 0; i < MV; i++) begin
                           if (CNT_W'(i) >= off_hit && CNT_W'(i + 1) < count_ff)
                              cell_ctrl[i].op = CELL_SHIFT;
                        end
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_TICK: begin
                     acc_in   = '0;
                     j_in     = '0;
                     state_in = ST_FSTART;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FSTART: begin
            fdiv_start = 1'b1;
            state_in   = ST_FDIV;
         end
         ST_FDIV: begin
            if (fdiv_done) begin
               exp_start = 1'b1;
               e16_in    = fdiv_q[EXPF_W];
               state_in  = ST_FEXP;
            end
         end
         ST_FEXP: begin
            if (exp_done) begin
               mult_shift = 1'b1;
               mult_new   = e16_ff ? {exp_m[MULT_W-2:0], 1'b0} : exp_m;
               if (j_ff == JW'(D - 1)) begin
                  s_in     = '0;
                  state_in = ST_VOICE;
               end else begin
                  j_in     = j_ff + JW'(1);
                  state_in = ST_FSTART;
               end
            end
         end
         ST_VOICE: begin
            if (s_ff == CNT_W'(MV)) begin
               state_in = ST_MIX1;
            end else if (s_ff < count_ff) begin
               base_in  = base_calc;
               k_in     = '0;
               state_in = ST_MUL;
            end else begin
               for (int i = 0; i < MV; i++) cell_ctrl[i].op = CELL_SHIFT;
               s_in = s_ff + CNT_W'(1);
            end
         end
         ST_MUL: begin
            prod_in  = {32'b0, base_ff} * {32'b0, mult_ff[0]};
            state_in = ST_ISTART;
         end
         ST_ISTART: begin
            div_start = 1'b1;
            state_in  = ST_IDIV;
         end
         ST_IDIV: begin
            if (div_done) begin
               cell_ctrl[0].op = CELL_PROC;
               mult_shift      = 1'b1;
               acc_in          = acc_ff + term;
               if (k_ff == JW'(D - 1)) begin
                  state_in = ST_ROT;
               end else begin
                  k_in     = k_ff + JW'(1);
                  state_in = ST_MUL;
               end
            end
         end
         ST_ROT: begin
            // advance the ring so the next voice sits in cell 0
            for (int i = 0; i < MV; i++) cell_ctrl[i].op = CELL_SHIFT;
            s_in     = s_ff + CNT_W'(1);
            state_in = ST_VOICE;
         end
         ST_MIX1: begin
            p1_in    = P1_W'(acc_ff) * COEF_P;
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            p2_in    = P2_W'(y_val) * $signed(P2_W'(volume_ff));
            state_in = ST_MIX3;
         end
         ST_MIX3: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (z_val > Z_MAX)      rsp_data_in = OUT_W'(OUT_MAX);
               else if (z_val < Z_MIN) rsp_data_in = OUT_W'(OUT_MIN);
               else                    rsp_data_in = z_val[OUT_W-1:0];
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         s_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         s_ff         <= s_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      prod_ff     <= prod_in;
      e16_ff      <= e16_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      rsp_data_ff <= rsp_data_in;
   end

   // factor line: shift in new factors, rotate while a voice is processed
   always_ff @(posedge clock) begin
      if (mult_shift) begin
         for (int i = 0; i < D - 1; i++) mult_ff[i] <= mult_ff[i+1];
         mult_ff[D-1] <= mult_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff <= '0;
         detune_ff <= '0;
         volume_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OCTAVE: octave_ff <= csr_data[OCT_W-1:0];
            CSR_DETUNE: detune_ff <= csr_data[DET_W-1:0];
            CSR_GAIN:   volume_ff <= csr_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_data_ff;

endmodule

// ===== rtl/core/psaw_checker.sv =====
// Port-level checks of the saw bank and their bind to the top level.
module psaw_checker import psaw_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [CMD_W-1:0]        req_cmd,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_sample_value
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output beat survives reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_value))
      else $error("stalled output beat changed");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_TICK |=> !req_ready)
      else $error("tick did not start the sequencer");

   a_note_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != CMD_TICK |=> req_ready)
      else $error("note beat blocked the input");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result issued while sequencer busy");

endmodule

bind poly_detuned_saw_bank psaw_checker u_psaw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sample_value (rsp_sample_value)
);

// ===== tb/poly_detuned_saw_bank_test.sv =====
// Self-checking testbench for the polyphonic detuned saw bank.
module poly_detuned_saw_bank_test;
   import psaw_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_NONE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;
   localparam int                   NV         = MAX_VOICES_DEF;
   localparam int                   ND         = DETUNE_VOICES_DEF;
   localparam int                   PB         = PHASE_BITS_DEF;
   localparam int                   WDOG_LIMIT = 40000;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [NOTE_W-1:0] note;
   } synth_cmd_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_cmd;
   logic [NOTE_W-1:0]      req_note_number;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic signed [OUT_W-1:0] rsp_sample_value;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   poly_detuned_saw_bank dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   synth_cmd_type       pending_cmds[$];
   logic [OUT_W-1:0]    expected_samples[$];
   bit                  req_took;
   bit                  running;
   bit                  failed;
   int                  send_idle_pct;
   int                  recv_stall_pct;
   bit                  hold_go;
   bit                  hold_done;
   int                  hold_cnt;
   int                  quiet_cycles;

   // model state
   logic [63:0]         root_q30[17];
   logic [2:0]          cfg_octave;
   logic [6:0]          cfg_detune;
   logic [15:0]         cfg_gain;
   logic [NOTE_W-1:0]   bank_notes[NV];
   int                  bank_count;
   logic [PB-1:0]       bank_phase[NV*ND];

   // generator-side view of active notes
   logic [NOTE_W-1:0]   gen_notes[$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         sq = 128'(t) * 128'(t);
         if (sq <= 128'(x)) r = t;
      end
      return r;
   endfunction

   function automatic logic [63:0] pow2_frac(input logic [15:0] f);
      logic [63:0] m;
      m = 64'd1 << 30;
      for (int i = 1; i <= 16; i++)
         if (f[16-i]) m = (m * root_q30[i]) >> 30;
      return m;
   endfunction

   function automatic logic [63:0] note_hz_q16(input logic [NOTE_W-1:0] n);
      int          t;
      int          s;
      logic [63:0] x;
      t = int'(n) + 3;
      s = 14 - (t / 12 - 6);
      x = 64'd440 * pow2_frac(16'(((t % 12) * 65536 + 6) / 12));
      return ((x + (64'd1 << (s - 1))) >> s) + (64'(cfg_octave) << 16);
   endfunction

   function automatic logic [PB-1:0] copy_step(input logic [63:0] hz, input int j);
      longint      e;
      logic [63:0] mult;
      logic [63:0] t2;
      e = ((longint'(1200 * (ND - 1)) + longint'(cfg_detune) * (2 * j - (ND - 1))) * 65536
           + 600 * (ND - 1)) / (1200 * (ND - 1));
      mult = pow2_frac(16'(e)) << (e >> 16);
      t2 = (hz * mult) / 64'(SAMPLE_RATE);
      return PB'((t2 + (64'd1 << (46 - PB - 1))) >> (46 - PB));
   endfunction

   // Apply one accepted beat; returns 1 with the sample when a tick.
   function automatic bit advance_bank(input synth_cmd_type c, output logic [OUT_W-1:0] smp);
      longint      acc;
      longint      y;
      longint      z;
      logic [63:0] hz;
      int          idx;
      smp = '0;
      if (c.cmd == CMD_NOTE_ON) begin
         if (bank_count < NV) begin
            bank_notes[bank_count] = c.note;
            for (int k = 0; k < ND; k++) bank_phase[bank_count*ND+k] = PB'(1) << (PB - 1);
            bank_count++;
         end
         return 0;
      end
      if (c.cmd == CMD_NOTE_OFF) begin
         for (int v = 0; v < bank_count; v++) begin
            if (bank_notes[v] == c.note) begin
               for (int w = v; w + 1 < bank_count; w++) begin
                  bank_notes[w] = bank_notes[w+1];
                  for (int k = 0; k < ND; k++) bank_phase[w*ND+k] = bank_phase[(w+1)*ND+k];
               end
               bank_count--;
               break;
            end
         end
         return 0;
      end
      if (c.cmd != CMD_TICK) return 0;
      acc = 0;
      for (int v = 0; v < bank_count; v++) begin
         hz = note_hz_q16(bank_notes[v]);
         for (int k = 0; k < ND; k++) begin
            idx = v * ND + k;
            bank_phase[idx] = bank_phase[idx] + copy_step(hz, k);
            acc += longint'(bank_phase[idx]) - (longint'(1) << (PB - 1));
         end
      end
      y = (acc * MIX_COEF + (longint'(1) << (PB + 1))) >>> (PB + 2);
      z = (y * longint'(cfg_gain) + 32768) >>> 16;
      if (z > OUT_MAX) z = OUT_MAX;
      if (z < OUT_MIN) z = OUT_MIN;
      smp = OUT_W'(z);
      return 1;
   endfunction

   // sender
   always @(negedge clock) begin
      synth_cmd_type c;
      if (running && (!req_valid || req_took)) begin
         if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            c = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_cmd <= c.cmd;
            req_note_number <= c.note;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver; the long hold-off is counted here
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_cnt = 2000;
         hold_done = 1;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= running && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      synth_cmd_type    c;
      logic [OUT_W-1:0] smp;
      logic [OUT_W-1:0] want;
      req_took = req_valid && req_ready && !reset;
      if (req_took) begin
         c.cmd = req_cmd;
         c.note = req_note_number;
         if (advance_bank(c, smp)) expected_samples.insert(expected_samples.size(), smp);
      end
      if (rsp_valid && rsp_ready && !reset) begin
         if (expected_samples.size() == 0) begin
            $error("sample_value beat with no tick pending: %0d", rsp_sample_value);
            failed = 1;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample_value !== want) begin
               $error("sample_value expected %0d got %0d", $signed(want), rsp_sample_value);
               failed = 1;
            end
         end
      end
      if (req_took || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) quiet_cycles = 0;
      else if (running) quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("poly_detuned_saw_bank verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_OCTAVE: cfg_octave = val[2:0];
         CSR_DETUNE: cfg_detune = val[6:0];
         CSR_GAIN:   cfg_gain = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] note);
      synth_cmd_type c;
      c.cmd = cmd;
      c.note = note;
      pending_cmds.insert(pending_cmds.size(), c);
      if (cmd == CMD_NOTE_ON && gen_notes.size() < NV) gen_notes.insert(gen_notes.size(), note);
      if (cmd == CMD_NOTE_OFF)
         foreach (gen_notes[i])
            if (gen_notes[i] == note) begin
               gen_notes.delete(i);
               break;
            end
   endtask

   // Mostly well-formed play: note-ons, releases of held notes, ticks.
   task automatic play_random(input int n, input int max_held, input int tick_pct);
      int roll;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < tick_pct)
            send(CMD_TICK, 7'($urandom));
         else if (roll < tick_pct + 4)
            send(CMD_NONE, 7'($urandom));
         else if (roll < tick_pct + 9)
            send(CMD_NOTE_OFF, 7'($urandom));
         else if (gen_notes.size() > 0 &&
                  (gen_notes.size() >= max_held || $urandom_range(1) == 0))
            send(CMD_NOTE_OFF, gen_notes[$urandom_range(gen_notes.size() - 1)]);
         else
            send(CMD_NOTE_ON, 7'($urandom));
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() > 0 || req_valid || expected_samples.size() > 0);
      // note beats may still be settling after the last sample
      repeat (40) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      running = 0;
      req_valid = 1'b0;
      req_cmd = CMD_NOTE_ON;
      req_note_number = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_OCTAVE;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      root_q30[0] = 64'd1 << 31;
      for (int i = 1; i <= 16; i++) root_q30[i] = int_sqrt(root_q30[i-1] << 30);
      cfg_octave = 0;
      cfg_detune = 0;
      cfg_gain = 0;
      bank_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      running = 1;

      // directed: empty bank, extreme notes, full bank, stray commands
      send(CMD_TICK, 7'h7F);
      drain();
      write_reg(CSR_GAIN, 16'hFFFF);
      write_reg(CSR_DETUNE, 16'd100);
      write_reg(CSR_OCTAVE, 16'd6);
      write_reg(CSR_SPARE, 16'hFFFF);
      send(CMD_TICK, 7'd0);
      send(CMD_NOTE_ON, 7'd0);
      send(CMD_NOTE_ON, 7'd127);
      send(CMD_TICK, 7'd0);
      send(CMD_TICK, 7'd0);
      for (int i = 0; i < 7; i++) send(CMD_NOTE_ON, 7'(60 + i * 5));
      send(CMD_TICK, 7'd0);
      send(CMD_NOTE_OFF, 7'd1);
      send(CMD_NONE, 7'd0);
      send(CMD_NOTE_OFF, 7'd65);
      send(CMD_NOTE_OFF, 7'd0);
      send(CMD_TICK, 7'd0);
      drain();
      write_reg(CSR_OCTAVE, 16'hFFFF);
      write_reg(CSR_DETUNE, 16'hFFFF);
      send(CMD_TICK, 7'd0);
      send(CMD_TICK, 7'd0);
      for (int i = 0; i < 8; i++) send(CMD_NOTE_OFF, 7'(60 + i * 5));
      send(CMD_NOTE_OFF, 7'd127);
      send(CMD_TICK, 7'd0);
      drain();

      // random phases across register settings and idling patterns
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_OCTAVE, 16'($urandom_range(7)));
         write_reg(CSR_DETUNE, ph == 0 ? 16'd0 : 16'($urandom_range(127)));
         write_reg(CSR_GAIN, ph == 1 ? 16'd0 : 16'($urandom));
         send_idle_pct = (ph == 1 || ph == 3) ? 77 : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? 77 : 0;
         if (ph == 3) begin
            send_idle_pct = 13;
            recv_stall_pct = 13;
         end
         play_random(140, ph == 0 ? 8 : 4, 30);
         drain();
      end

      // fill the block while the receiver holds off
      write_reg(CSR_GAIN, 16'hFFFF);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send(CMD_NOTE_ON, 7'd69);
      for (int i = 0; i < 10; i++) send(CMD_TICK, 7'd0);
      hold_go = 1;
      play_random(60, 3, 40);
      drain();

      if (!failed) begin
         $display("poly_detuned_saw_bank verification clean");
      end else begin
         $display("poly_detuned_saw_bank verification failed");
      end
      $finish;
   end

endmodule
